FILE: hdl/assert_macros.svh
// shared assertion macros for the heap selector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// consequent checked in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rstn, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) \
        else $error(msg);

`endif

FILE: hdl/hks_pkg.sv
`timescale 1ns / 1ps
package hks_pkg;

    localparam int HEAP_DEPTH  = 64;
    localparam int OP_W        = 2;
    localparam int IDX_W       = 16;
    localparam int WT_W        = 32;
    localparam int SLOT_W      = 6;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    localparam logic [CFG_DATA_W-1:0] CAP_RESET = 7'd64;

    // request operations
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_APPEND  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROP    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_CAPACITY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEEP_MODE       = 2'd1;

    typedef struct packed {
        logic [IDX_W-1:0]       idx;
        logic signed [WT_W-1:0] wt;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_UP      = 9'b000000010,
        S_UP_CMP  = 9'b000000100,
        S_ROOT    = 9'b000001000,
        S_DN      = 9'b000010000,
        S_DN_LR   = 9'b000100000,
        S_DN_CMP  = 9'b001000000,
        S_RD      = 9'b010000000,
        S_EMIT    = 9'b100000000
    } state_t;

endpackage

FILE: hdl/hks_ram.sv
`timescale 1ns / 1ps
module hks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: hdl/hks_cmp.sv
`timescale 1ns / 1ps
module hks_cmp import hks_pkg::*; (
    input  logic                   keep_mode,
    input  logic signed [WT_W-1:0] a,
    input  logic signed [WT_W-1:0] b,
    output logic                   above
);

    // a belongs nearer the root than b: min-heap in mode 0, max-heap in mode 1
    assign above = keep_mode ? (a > b) : (a < b);

endmodule

FILE: hdl/top_k_heap_selector_top.sv
`timescale 1ns / 1ps
// Top-K heap selector: keeps the best (index, weight) pairs of a stream in a binary heap held
// in one dual-read ram, with one weight comparator shared by every step under a small
// sequencer. Each request carries an operation in s_tuser (insert, read slot, clear) and one
// result comes back per request, status in m_tuser. While a request is worked on s_tready is
// low; a finished result sits in the output register so the next request can start while it
// waits; the result shows on m_tvalid in the same cycle that s_tready rises again. An append
// climbs one heap level per parent read and compare; a root replacement sinks one level per
// read of both children, a pick between them and a compare with the carried item. The single
// comparator makes one compare per cycle, and each heap level needs one ram read.
// Configuration (active capacity, keep mode) is written on the cfg port; the user must write
// it only while no request is in flight, as the block itself does not enforce this; no
// clearing pass is needed after reset since slots are read only below the count.
`include "assert_macros.svh"
module top_k_heap_selector_top import hks_pkg::*; #(
    parameter int CAPACITY = HEAP_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // request channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // item_index, item_weight, slot, zero pad
    input  logic [OP_W-1:0]        s_tuser,   // operation
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // entry_count, read_valid, read_index, read_weight
    output logic [STATUS_W-1:0]    m_tuser,   // status
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(CAPACITY);        // heap address width
    localparam int CW = $clog2(CAPACITY + 1);    // entry count width
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;  // width for count compares
    localparam int PW = AW + 2;                  // child position width

    // request fields
    logic [IDX_W-1:0]       in_idx;
    logic signed [WT_W-1:0] in_wt;
    logic [SLOT_W-1:0]      in_slot;
    logic                   in_acc;

    assign in_idx  = s_tdata[15:0];
    assign in_wt   = s_tdata[47:16];
    assign in_slot = s_tdata[53:48];
    assign in_acc  = s_tvalid && s_tready;

    // sequencer state
    state_t               state_reg, state_next;
    logic [CW-1:0]        held_reg, held_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        child_pos_reg, child_pos_next;
    entry_t               carry_reg, carry_next;     // item being placed
    entry_t               child_reg, child_next;     // chosen child on the way down
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 rvalid_reg, rvalid_next;
    entry_t               rdat_reg, rdat_next;

    // configuration
    logic [CFG_DATA_W-1:0] cap_reg, cap_next;
    logic                  mode_reg, mode_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [COUNT_W-1:0]    m_count_reg, m_count_next;
    logic                  m_rvalid_reg, m_rvalid_next;
    entry_t                m_rdat_reg, m_rdat_next;

    // heap ram
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    entry_t                ram_wdata;
    logic [AW-1:0]         ram_raddr_a;
    logic [AW-1:0]         ram_raddr_b;
    logic [ENTRY_W-1:0]    ram_rdata_a;
    logic [ENTRY_W-1:0]    ram_rdata_b;
    entry_t                rd_a;
    entry_t                rd_b;

    // shared comparator
    logic signed [WT_W-1:0] cmp_a;
    logic signed [WT_W-1:0] cmp_b;
    logic                   cmp_above;

    hks_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    assign rd_a = entry_t'(ram_rdata_a);
    assign rd_b = entry_t'(ram_rdata_b);

    hks_cmp u_cmp (
        .keep_mode (mode_reg),
        .a         (cmp_a),
        .b         (cmp_b),
        .above     (cmp_above)
    );

    // effective capacity: zero acts as one, clipped to the ram depth
    logic [XW-1:0] cap_x;
    logic [XW-1:0] cap_eff;
    logic [XW-1:0] held_x;
    logic          heap_full;
    logic          nonpos;
    logic          read_ok;
    logic [AW-1:0] slot_addr;

    assign cap_x  = XW'(cap_reg);
    assign held_x = XW'(held_reg);

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = XW'(1);
        end else if (cap_x > XW'(CAPACITY)) begin
            cap_eff = XW'(CAPACITY);
        end else begin
            cap_eff = cap_x;
        end
    end

    assign heap_full = (held_x >= cap_eff);
    assign nonpos    = in_wt[WT_W-1] || (in_wt == '0);
    assign read_ok   = (XW'(in_slot) < held_x) && (XW'(in_slot) < XW'(CAPACITY));
    assign slot_addr = AW'(in_slot);

    // heap navigation
    logic [AW-1:0] pos_m1;
    logic [AW-1:0] parent_addr;
    logic [PW-1:0] left_x;
    logic [PW-1:0] right_x;
    logic          has_left;
    logic          has_right;

    assign pos_m1      = pos_reg - AW'(1);
    assign parent_addr = pos_m1 >> 1;
    assign left_x      = PW'({pos_reg, 1'b1});
    assign right_x     = left_x + PW'(1);
    assign has_left    = left_x < PW'(held_reg);
    assign has_right   = right_x < PW'(held_reg);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // configuration writes
    always_comb begin
        cap_next  = cap_reg;
        mode_next = mode_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ACTIVE_CAPACITY: cap_next  = cfg_data;
                REG_KEEP_MODE:       mode_next = cfg_data[0];
                default:             ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        held_next      = held_reg;
        pos_next       = pos_reg;
        child_pos_next = child_pos_reg;
        carry_next     = carry_reg;
        child_next     = child_reg;
        status_next    = status_reg;
        rvalid_next    = rvalid_reg;
        rdat_next      = rdat_reg;

        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        m_rvalid_next = m_rvalid_reg;
        m_rdat_next   = m_rdat_reg;

        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = carry_reg;
        ram_raddr_a = '0;
        ram_raddr_b = right_x[AW-1:0];

        cmp_a = carry_reg.wt;
        cmp_b = carry_reg.wt;

        case (state_reg)
            S_IDLE: begin
                // root read is issued speculatively for a full-heap insert
                ram_raddr_a = (s_tuser == OP_READ) ? slot_addr : '0;
                if (in_acc) begin
                    rvalid_next = 1'b0;
                    rdat_next   = '0;
                    carry_next  = '{idx: in_idx, wt: in_wt};
                    case (s_tuser)
                        OP_INSERT: begin
                            if (!mode_reg && nonpos) begin
                                status_next = ST_DROP;
                                state_next  = S_EMIT;
                            end else if (!heap_full) begin
                                pos_next    = AW'(held_reg);
                                held_next   = held_reg + CW'(1);
                                status_next = ST_APPEND;
                                state_next  = S_UP;
                            end else begin
                                state_next = S_ROOT;
                            end
                        end
                        OP_READ: begin
                            status_next = ST_DONE;
                            state_next  = read_ok ? S_RD : S_EMIT;
                        end
                        OP_CLEAR: begin
                            held_next   = '0;
                            status_next = ST_DONE;
                            state_next  = S_EMIT;
                        end
                        default: begin
                            status_next = ST_DONE;
                            state_next  = S_EMIT;
                        end
                    endcase
                end
            end
            S_UP: begin
                if (pos_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    ram_raddr_a = parent_addr;
                    state_next  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                // move the parent down into the hole while the new item beats it
                cmp_a  = carry_reg.wt;
                cmp_b  = rd_a.wt;
                ram_we = 1'b1;
                if (cmp_above) begin
                    ram_wdata  = rd_a;
                    pos_next   = parent_addr;
                    state_next = S_UP;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_ROOT: begin
                cmp_a = rd_a.wt;
                cmp_b = carry_reg.wt;
                if (cmp_above) begin
                    status_next = ST_REPLACE;
                    pos_next    = '0;
                    state_next  = S_DN;
                end else begin
                    status_next = ST_REJECT;
                    state_next  = S_EMIT;
                end
            end
            S_DN: begin
                if (!has_left) begin
                    ram_we     = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    ram_raddr_a = left_x[AW-1:0];
                    ram_raddr_b = right_x[AW-1:0];
                    state_next  = S_DN_LR;
                end
            end
            S_DN_LR: begin
                // right child wins only when present and strictly better
                cmp_a = rd_b.wt;
                cmp_b = rd_a.wt;
                if (has_right && cmp_above) begin
                    child_next     = rd_b;
                    child_pos_next = right_x[AW-1:0];
                end else begin
                    child_next     = rd_a;
                    child_pos_next = left_x[AW-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                cmp_a  = child_reg.wt;
                cmp_b  = carry_reg.wt;
                ram_we = 1'b1;
                if (cmp_above) begin
                    ram_wdata  = child_reg;
                    pos_next   = child_pos_reg;
                    state_next = S_DN;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_RD: begin
                rvalid_next = 1'b1;
                rdat_next   = rd_a;
                state_next  = S_EMIT;
            end
            S_EMIT: begin
                // hand the result over once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_count_next  = COUNT_W'(held_reg);
                    m_rvalid_next = rvalid_reg;
                    m_rdat_next   = rdat_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            held_reg    <= '0;
            cap_reg     <= CAP_RESET;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            cap_reg     <= cap_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        child_pos_reg <= child_pos_next;
        carry_reg     <= carry_next;
        child_reg     <= child_next;
        status_reg    <= status_next;
        rvalid_reg    <= rvalid_next;
        rdat_reg      <= rdat_next;
        m_status_reg  <= m_status_next;
        m_count_reg   <= m_count_next;
        m_rvalid_reg  <= m_rvalid_next;
        m_rdat_reg    <= m_rdat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_rdat_reg.wt, m_rdat_reg.idx, m_rvalid_reg, m_count_reg};

    // checks
    `ASSERT_CLK(a_held_bound, aclk, aresetn, held_x <= XW'(CAPACITY), "count beyond heap depth")
    `ASSERT_CLK(a_write_in_heap, aclk, aresetn, !ram_we || (XW'(ram_waddr) < held_x), "heap write outside held entries")
    `ASSERT_NEXT(a_clear_empties, aclk, aresetn, in_acc && (s_tuser == OP_CLEAR), held_reg == '0, "clear left entries")

endmodule
